[rtl/kdpe_pkg.sv]
// ----------------------------------------------------------------------------
// kdpe_pkg
// Shared types and constants for the keypad debounce and press event block.
// ----------------------------------------------------------------------------
package kdpe_pkg;

  // Default number of keys scanned per tick
  localparam int KEY_COUNT_DEF = 8;

  // Field widths
  localparam int TS_W    = 32;
  localparam int CFG_W   = 16;
  localparam int MASK_W  = 8;
  localparam int KEY_W   = 3;
  localparam int KIND_W  = 3;
  localparam int IDX_W   = 3;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 72;
  localparam int OUT_PAD = OUT_W - (KEY_W + TS_W + TS_W);

  // Remainder unit: one quotient bit per cycle over the timestamp width
  localparam int DIV_STEPS = TS_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT_START  = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT_MASK   = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0]  DEBOUNCE_RST      = 16'd30;
  localparam logic [CFG_W-1:0]  LONG_PRESS_RST    = 16'd1000;
  localparam logic [CFG_W-1:0]  REPEAT_START_RST  = 16'd500;
  localparam logic [CFG_W-1:0]  REPEAT_PERIOD_RST = 16'd100;
  localparam logic [MASK_W-1:0] REPEAT_MASK_RST   = 8'd0;

  // Event kinds
  typedef enum logic [KIND_W-1:0] {
    EV_PRESSED  = 3'd0,
    EV_RELEASED = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_REPEAT   = 3'd4
  } ev_kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_DEB,
    ST_PRESS,
    ST_REL,
    ST_SHORT,
    ST_LONG,
    ST_REP,
    ST_DIV,
    ST_REPEMIT,
    ST_REPUPD,
    ST_FLUSH
  } state_t;

  // One event
  typedef struct packed {
    logic [KEY_W-1:0] key;
    ev_kind_t         kind;
    logic [TS_W-1:0]  time_ms;
    logic [TS_W-1:0]  held;
  } ev_t;

  // Sequencer to event buffer
  typedef struct packed {
    logic push;
    logic flush;
    ev_t  ev;
  } evbuf_ctl_t;

endpackage

[rtl/kdpe_alu.sv]
// ----------------------------------------------------------------------------
// kdpe_alu
// Shared timestamp adder/subtractor with threshold compare and sign flag.
// ----------------------------------------------------------------------------
module kdpe_alu (
  input  logic [kdpe_pkg::TS_W-1:0]  a,
  input  logic [kdpe_pkg::TS_W-1:0]  b,
  input  logic                       sub,
  input  logic [kdpe_pkg::CFG_W-1:0] thr,
  output logic [kdpe_pkg::TS_W-1:0]  sum,
  output logic                       ge_thr,
  output logic                       neg
);

  logic [kdpe_pkg::TS_W-1:0] b_op;

  // Add, or subtract through inverted operand and carry in
  assign b_op   = sub ? ~b : b;
  assign sum    = a + b_op + {{(kdpe_pkg::TS_W-1){1'b0}}, sub};
  assign ge_thr = sum >= {{(kdpe_pkg::TS_W-kdpe_pkg::CFG_W){1'b0}}, thr};
  assign neg    = sum[kdpe_pkg::TS_W-1];

endmodule

[rtl/kdpe_remdiv.sv]
// ----------------------------------------------------------------------------
// kdpe_remdiv
// Restoring remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module kdpe_remdiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kdpe_pkg::TS_W-1:0]  dividend,
  input  logic [kdpe_pkg::CFG_W-1:0] divisor,
  output logic                       done,
  output logic [kdpe_pkg::CFG_W-1:0] rem
);

  logic                        run;
  logic [kdpe_pkg::DIV_CW-1:0] cnt;
  logic [kdpe_pkg::TS_W-1:0]   dvd;
  logic [kdpe_pkg::CFG_W-1:0]  dsr;
  logic [kdpe_pkg::CFG_W:0]    trial;
  logic                        fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, dvd[kdpe_pkg::TS_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      if (cnt == kdpe_pkg::DIV_CW'(kdpe_pkg::DIV_STEPS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[kdpe_pkg::TS_W-2:0], 1'b0};
      rem <= fits ? kdpe_pkg::CFG_W'(trial - {1'b0, dsr}) : trial[kdpe_pkg::CFG_W-1:0];
    end
  end

endmodule

[rtl/kdpe_evbuf.sv]
// ----------------------------------------------------------------------------
// kdpe_evbuf
// Holds back one event until the next one or the end of the tick shows whether
// it is the last, then hands it to the output register.
// ----------------------------------------------------------------------------
module kdpe_evbuf (
  input  logic                         clk,
  input  logic                         rst,
  input  kdpe_pkg::evbuf_ctl_t         ctl,
  output logic                         room,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // m_axis_tdata: key_index[2:0], event_time_ms[34:3], held_ms[66:35], zeros
  output logic [kdpe_pkg::OUT_W-1:0]   m_axis_tdata,
  // m_axis_tuser: event_kind[2:0]
  output logic [kdpe_pkg::KIND_W-1:0]  m_axis_tuser,
  output logic                         m_axis_tlast
);

  logic          pend_v;
  kdpe_pkg::ev_t pend;
  kdpe_pkg::ev_t out_ev;
  logic          out_last;
  logic          out_free;
  logic          move;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign room     = !pend_v || out_free;
  assign move     = pend_v && out_free && (ctl.push || ctl.flush);

  // Pending word
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (ctl.push && room) begin
      pend_v <= 1'b1;
    end else if (ctl.flush && room) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && room) begin
      pend <= ctl.ev;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= move || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_ev   <= pend;
      out_last <= ctl.flush;
    end
  end

  assign m_axis_tdata = {{kdpe_pkg::OUT_PAD{1'b0}}, out_ev.held, out_ev.time_ms, out_ev.key};
  assign m_axis_tuser = out_ev.kind;
  assign m_axis_tlast = out_last;

endmodule

[rtl/key_debounce_press_event_generator.sv]
// ----------------------------------------------------------------------------
// key_debounce_press_event_generator
// Keypad debounce with pressed, released, short, long and auto-repeat events.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tdata: key_mask[7:0], now_ms[39:8]
//   m_axis   | out       | tdata: key_index, event_time_ms, held_ms;
//            |           | tuser: event_kind; tlast: final event of the tick
//   cfg      | in        | cfg_index selects register, cfg_data the value
//
// A sequencer visits one key at a time and drives a shared 32-bit adder.
// Each key passes through raw, debounce, long-press and repeat states; each
// pressed, released or short event adds a state, and each repeat event adds a
// wait on the one-bit-a-cycle remainder unit that realigns the repeat schedule.
// s_axis_tready is high only while idle; a stalled output holds the sequencer.
// Reset is synchronous and clears all per-key flags and the registers.
// ----------------------------------------------------------------------------
module key_debounce_press_event_generator #(
  parameter int KEY_COUNT = kdpe_pkg::KEY_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // s_axis_tdata: key_mask[7:0], now_ms[39:8]
  input  logic [kdpe_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // m_axis_tdata: key_index[2:0], event_time_ms[34:3], held_ms[66:35], zeros
  output logic [kdpe_pkg::OUT_W-1:0]   m_axis_tdata,
  // m_axis_tuser: event_kind[2:0]
  output logic [kdpe_pkg::KIND_W-1:0]  m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kdpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [kdpe_pkg::CFG_W-1:0]   cfg_data
);

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(KEY_COUNT - 1);

  kdpe_pkg::state_t state, state_next;

  logic [KW-1:0]                 k;
  logic [kdpe_pkg::MASK_W-1:0]   mask_q;
  logic [kdpe_pkg::TS_W-1:0]     now_q;

  logic [kdpe_pkg::CFG_W-1:0]    debounce_ms;
  logic [kdpe_pkg::CFG_W-1:0]    long_press_ms;
  logic [kdpe_pkg::CFG_W-1:0]    repeat_start_ms;
  logic [kdpe_pkg::CFG_W-1:0]    repeat_period_ms;
  logic [kdpe_pkg::MASK_W-1:0]   repeat_key_mask;

  logic                          raw_state    [KEY_COUNT];
  logic                          stable_state [KEY_COUNT];
  logic                          long_done    [KEY_COUNT];
  logic [kdpe_pkg::TS_W-1:0]     change_time      [KEY_COUNT];
  logic [kdpe_pkg::TS_W-1:0]     press_time       [KEY_COUNT];
  logic [kdpe_pkg::TS_W-1:0]     next_repeat_time [KEY_COUNT];

  logic                          raw_k, stable_k, long_k;
  logic [kdpe_pkg::CFG_W-1:0]    period_eff;
  logic                          last_key;

  logic [kdpe_pkg::TS_W-1:0]     alu_b;
  logic                          alu_sub;
  logic [kdpe_pkg::CFG_W-1:0]    alu_thr;
  logic [kdpe_pkg::TS_W-1:0]     alu_sum;
  logic                          alu_ge;
  logic                          alu_neg;

  logic                          div_start;
  logic                          div_done;
  logic [kdpe_pkg::CFG_W-1:0]    div_rem;

  kdpe_pkg::evbuf_ctl_t          ev_ctl;
  logic                          room;

  logic                          deb_hit, long_hit, rep_hit;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == kdpe_pkg::ST_IDLE);

  assign raw_k      = raw_state[k];
  assign stable_k   = stable_state[k];
  assign long_k     = long_done[k];
  assign period_eff = (repeat_period_ms == '0) ? kdpe_pkg::CFG_W'(1) : repeat_period_ms;
  assign last_key   = (k == K_LAST);

  // Per-key decisions, each read off the shared unit in its own state
  assign deb_hit  = (raw_k != stable_k) && alu_ge;
  assign long_hit = stable_k && !long_k && alu_ge;
  assign rep_hit  = stable_k && repeat_key_mask[k] && !alu_neg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= kdpe_pkg::DEBOUNCE_RST;
      long_press_ms    <= kdpe_pkg::LONG_PRESS_RST;
      repeat_start_ms  <= kdpe_pkg::REPEAT_START_RST;
      repeat_period_ms <= kdpe_pkg::REPEAT_PERIOD_RST;
      repeat_key_mask  <= kdpe_pkg::REPEAT_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdpe_pkg::REG_DEBOUNCE:      debounce_ms      <= cfg_data;
        kdpe_pkg::REG_LONG_PRESS:    long_press_ms    <= cfg_data;
        kdpe_pkg::REG_REPEAT_START:  repeat_start_ms  <= cfg_data;
        kdpe_pkg::REG_REPEAT_PERIOD: repeat_period_ms <= cfg_data;
        kdpe_pkg::REG_REPEAT_MASK:   repeat_key_mask  <= cfg_data[kdpe_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared timestamp unit
  kdpe_alu u_alu (
    .a      (now_q),
    .b      (alu_b),
    .sub    (alu_sub),
    .thr    (alu_thr),
    .sum    (alu_sum),
    .ge_thr (alu_ge),
    .neg    (alu_neg)
  );

  // Remainder of overdue time by the repeat period
  kdpe_remdiv u_remdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (alu_sum),
    .divisor  (period_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Event hold-back and output register
  kdpe_evbuf u_evbuf (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ev_ctl),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kdpe_pkg::ST_IDLE:    if (s_axis_tvalid) state_next = kdpe_pkg::ST_RAW;
      kdpe_pkg::ST_RAW:     state_next = kdpe_pkg::ST_DEB;
      kdpe_pkg::ST_DEB: begin
        if (deb_hit) begin
          state_next = raw_k ? kdpe_pkg::ST_PRESS : kdpe_pkg::ST_REL;
        end else begin
          state_next = kdpe_pkg::ST_LONG;
        end
      end
      kdpe_pkg::ST_PRESS:   if (room) state_next = kdpe_pkg::ST_LONG;
      kdpe_pkg::ST_REL: begin
        if (room) state_next = long_k ? kdpe_pkg::ST_LONG : kdpe_pkg::ST_SHORT;
      end
      kdpe_pkg::ST_SHORT:   if (room) state_next = kdpe_pkg::ST_LONG;
      kdpe_pkg::ST_LONG:    if (!long_hit || room) state_next = kdpe_pkg::ST_REP;
      kdpe_pkg::ST_REP: begin
        if (rep_hit) begin
          state_next = kdpe_pkg::ST_DIV;
        end else begin
          state_next = last_key ? kdpe_pkg::ST_FLUSH : kdpe_pkg::ST_RAW;
        end
      end
      kdpe_pkg::ST_DIV:     if (div_done) state_next = kdpe_pkg::ST_REPEMIT;
      kdpe_pkg::ST_REPEMIT: if (room) state_next = kdpe_pkg::ST_REPUPD;
      kdpe_pkg::ST_REPUPD:  state_next = last_key ? kdpe_pkg::ST_FLUSH : kdpe_pkg::ST_RAW;
      kdpe_pkg::ST_FLUSH:   if (room) state_next = kdpe_pkg::ST_IDLE;
      default:              state_next = kdpe_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: unit operands, event pushes, divider start
  always_comb begin
    alu_b         = press_time[k];
    alu_sub       = 1'b1;
    alu_thr       = long_press_ms;
    div_start     = 1'b0;
    ev_ctl.push   = 1'b0;
    ev_ctl.flush  = 1'b0;
    ev_ctl.ev.key     = kdpe_pkg::KEY_W'(k);
    ev_ctl.ev.kind    = kdpe_pkg::EV_PRESSED;
    ev_ctl.ev.time_ms = now_q;
    ev_ctl.ev.held    = alu_sum;
    case (state)
      kdpe_pkg::ST_DEB: begin
        alu_b   = change_time[k];
        alu_thr = debounce_ms;
      end
      kdpe_pkg::ST_PRESS: begin
        alu_b          = {{(kdpe_pkg::TS_W-kdpe_pkg::CFG_W){1'b0}}, repeat_start_ms};
        alu_sub        = 1'b0;
        ev_ctl.push    = 1'b1;
        ev_ctl.ev.held = '0;
      end
      kdpe_pkg::ST_REL: begin
        ev_ctl.push    = 1'b1;
        ev_ctl.ev.kind = kdpe_pkg::EV_RELEASED;
      end
      kdpe_pkg::ST_SHORT: begin
        ev_ctl.push    = 1'b1;
        ev_ctl.ev.kind = kdpe_pkg::EV_SHORT;
      end
      kdpe_pkg::ST_LONG: begin
        ev_ctl.push    = long_hit;
        ev_ctl.ev.kind = kdpe_pkg::EV_LONG;
      end
      kdpe_pkg::ST_REP: begin
        alu_b     = next_repeat_time[k];
        div_start = rep_hit;
      end
      kdpe_pkg::ST_REPEMIT: begin
        ev_ctl.push    = 1'b1;
        ev_ctl.ev.kind = kdpe_pkg::EV_REPEAT;
      end
      kdpe_pkg::ST_REPUPD: begin
        alu_b   = kdpe_pkg::TS_W'(period_eff - div_rem);
        alu_sub = 1'b0;
      end
      kdpe_pkg::ST_FLUSH: begin
        ev_ctl.flush = 1'b1;
      end
      default: ;
    endcase
  end

  // Tick capture and key counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (state == kdpe_pkg::ST_IDLE) begin
      k <= '0;
    end else if (!last_key && ((state == kdpe_pkg::ST_REP && !rep_hit) ||
                               state == kdpe_pkg::ST_REPUPD)) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mask_q <= s_axis_tdata[kdpe_pkg::MASK_W-1:0];
      now_q  <= s_axis_tdata[kdpe_pkg::IN_W-1:kdpe_pkg::MASK_W];
    end
  end

  // Per-key flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        raw_state[i]    <= 1'b0;
        stable_state[i] <= 1'b0;
        long_done[i]    <= 1'b0;
      end
    end else begin
      case (state)
        kdpe_pkg::ST_RAW:   raw_state[k]    <= mask_q[k];
        kdpe_pkg::ST_DEB:   if (deb_hit) stable_state[k] <= raw_k;
        kdpe_pkg::ST_PRESS: if (room) long_done[k] <= 1'b0;
        kdpe_pkg::ST_LONG:  if (long_hit && room) long_done[k] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Per-key timestamps
  always_ff @(posedge clk) begin
    case (state)
      kdpe_pkg::ST_RAW: begin
        if (mask_q[k] != raw_k) change_time[k] <= now_q;
      end
      kdpe_pkg::ST_PRESS: begin
        if (room) begin
          press_time[k]       <= now_q;
          next_repeat_time[k] <= alu_sum;
        end
      end
      kdpe_pkg::ST_REPUPD: next_repeat_time[k] <= alu_sum;
      default: ;
    endcase
  end

endmodule

[rtl/kdpe_checker.sv]
// ----------------------------------------------------------------------------
// kdpe_checker
// Port-level checks for the keypad event block, bound to the top level.
// ----------------------------------------------------------------------------
module kdpe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [kdpe_pkg::OUT_W-1:0]   m_axis_tdata,
  input logic [kdpe_pkg::KIND_W-1:0]  m_axis_tuser,
  input logic                         m_axis_tlast
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // One tick at a time: busy right after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a tick is in progress");

  // Pressed events carry zero held time
  a_press_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == kdpe_pkg::EV_PRESSED |->
      m_axis_tdata[66:35] == '0)
    else $error("pressed event with nonzero held time");

  // Only defined event kinds and zero padding leave the block
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= kdpe_pkg::EV_REPEAT &&
      m_axis_tdata[kdpe_pkg::OUT_W-1:67] == '0)
    else $error("bad event kind or padding");

endmodule

bind key_debounce_press_event_generator kdpe_checker u_kdpe_checker (.*);
